// ===== sv/tse_pkg.sv =====
package tse_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths.
    localparam int VALUE_W     = 32;
    localparam int IN_INDEX_W  = 10;
    localparam int POS_W       = 10;
    localparam int CFG_COUNT_W = 11;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Operation codes.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Search mode codes.
    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_BINARY = 1'b1;

    // Register select codes (paddr bit 2).
    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_SEARCH_MODE = 1'b1;

    // A classified request as it travels from front to back.
    typedef struct packed {
        logic                      is_search;
        logic                      load_ok;
        logic [IDX_W-1:0]          index;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

// ===== sv/tse_if.sv =====
interface tse_req_if
    import tse_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [IN_INDEX_W-1:0]        entry_index;
    logic signed [VALUE_W-1:0]    value;

    modport source (output valid, output operation, output entry_index, output value,
                    input ready);
    modport sink   (input valid, input operation, input entry_index, input value,
                    output ready);
endinterface

interface tse_res_if
    import tse_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

// ===== sv/tse_front.sv =====
module tse_front
    import tse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tse_req_if.sink   req,
    output logic      cmd_valid,
    output cmd_t      cmd,
    input  logic      cmd_pop
);

    cmd_t               q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    cmd_t               new_cmd;
    logic               push;
    logic               pop;

    // Classify the incoming request.
    always_comb
    begin
        new_cmd.is_search = (req.operation == OP_SEARCH);
        new_cmd.load_ok   = (32'(req.entry_index) < 32'(TABLE_DEPTH));
        new_cmd.index     = IDX_W'(req.entry_index);
        new_cmd.value     = req.value;
    end

    assign req.ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/tse_back.sv =====
module tse_back
    import tse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  cmd_t             cmd,
    output logic             cmd_pop,
    input  logic [CNT_W-1:0] entry_count,
    input  logic             search_mode,
    tse_res_if.source        res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_CMP  = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic [VALUE_W-1:0]        mem [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] rd_reg;
    logic signed [VALUE_W-1:0] target_reg, target_next;
    logic [IDX_W-1:0]          addr_reg, addr_next;
    logic [CNT_W-1:0]          lo_reg, lo_next;
    logic [CNT_W-1:0]          hi_reg, hi_next;
    logic                      bin_reg, bin_next;
    logic                      res_valid_reg, res_valid_next;
    logic                      found_reg, found_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic                      mem_we;
    logic                      lt;
    logic [CNT_W-1:0]          lo_n;
    logic [CNT_W-1:0]          hi_n;
    logic [CNT_W:0]            mid_sum;
    logic [CNT_W:0]            start_sum;

    // Take a command only while idle; a search also waits for a free result register.
    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid
                     && (!cmd.is_search || !res_valid_reg);
    assign mem_we  = cmd_pop && !cmd.is_search && cmd.load_ok;

    assign res.valid    = res_valid_reg;
    assign res.found    = found_reg;
    assign res.position = pos_reg;

    // Binary step: narrow the half-open interval [lo, hi).
    assign lt        = (rd_reg < target_reg);
    assign lo_n      = lt ? (CNT_W'(addr_reg) + 1'b1) : lo_reg;
    assign hi_n      = lt ? hi_reg : CNT_W'(addr_reg);
    assign mid_sum   = ({1'b0, lo_n} + {1'b0, hi_n} - 1'b1) >> 1;
    assign start_sum = ({1'b0, entry_count} - 1'b1) >> 1;

    // Table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cmd.index] <= cmd.value;
        end
        if (state_reg == S_READ)
        begin
            rd_reg <= mem[addr_reg];
        end
    end

    // Search sequencer.
    always_comb
    begin
        state_next     = state_reg;
        target_next    = target_reg;
        addr_next      = addr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        bin_next       = bin_reg;
        res_valid_next = res_valid_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop && cmd.is_search)
                begin
                    target_next = cmd.value;
                    bin_next    = (search_mode == MODE_BINARY);
                    lo_next     = '0;
                    hi_next     = entry_count;
                    if (entry_count == '0)
                    begin
                        res_valid_next = 1'b1;
                        found_next     = 1'b0;
                        pos_next       = '0;
                    end
                    else
                    begin
                        addr_next  = (search_mode == MODE_BINARY) ? IDX_W'(start_sum) : '0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (rd_reg == target_reg)
                begin
                    res_valid_next = 1'b1;
                    found_next     = 1'b1;
                    pos_next       = POS_W'(addr_reg);
                    state_next     = S_IDLE;
                end
                else if (!bin_reg)
                begin
                    if ((CNT_W'(addr_reg) + 1'b1) >= entry_count)
                    begin
                        res_valid_next = 1'b1;
                        found_next     = 1'b0;
                        pos_next       = '0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    lo_next = lo_n;
                    hi_next = hi_n;
                    if (lo_n < hi_n)
                    begin
                        addr_next  = IDX_W'(mid_sum);
                        state_next = S_READ;
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        found_next     = 1'b0;
                        pos_next       = '0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Search datapath and result payload.
    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        addr_reg   <= addr_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        bin_reg    <= bin_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
    end

endmodule

// ===== sv/table_search_engine.sv =====
// Table search engine: keeps a table of signed 32-bit entries in a single-port
// memory with registered read. A load request writes one entry and gives no
// result; a search request gives one result (found flag and position) over the
// first entry_count entries, by first-match linear scan or by binary search on
// an ascending table. Requests enter a two-deep command queue, so the input side
// keeps accepting while the search sequencer works, until the queue is full. A
// load is written when the idle sequencer takes it. A search has a start step,
// then a read state and a compare state per memory probe, up to entry_count
// probes in linear mode and up to floor(log2(entry_count))+1 in binary mode. A
// search waits to start while the previous result has not been taken. Entries
// that were never written read as unknown values.
module table_search_engine
    import tse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tse_req_if.sink     req,
    tse_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0]       entry_count_reg;
    logic                   search_mode_reg;
    logic                   cfg_write;
    logic [CFG_COUNT_W-1:0] count_in;
    logic                   cmd_valid;
    logic                   cmd_pop;
    cmd_t                   cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign count_in  = pwdata[CFG_COUNT_W-1:0];

    // Configuration registers; entry_count saturates at the table depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            search_mode_reg <= MODE_LINEAR;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_ENTRY_COUNT:
                begin
                    if (32'(count_in) > 32'(TABLE_DEPTH))
                    begin
                        entry_count_reg <= CNT_W'(TABLE_DEPTH);
                    end
                    else
                    begin
                        entry_count_reg <= CNT_W'(count_in);
                    end
                end
                REG_SEARCH_MODE:
                begin
                    search_mode_reg <= pwdata[0];
                end
                default:
                begin
                    search_mode_reg <= search_mode_reg;
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[2])
            REG_ENTRY_COUNT: prdata = 32'(entry_count_reg);
            REG_SEARCH_MODE: prdata = {31'd0, search_mode_reg};
            default:         prdata = '0;
        endcase
    end

    tse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .entry_count (entry_count_reg),
        .search_mode (search_mode_reg),
        .res         (res)
    );

endmodule

// ===== dv/table_search_engine_tb.sv =====
module table_search_engine_tb
    import tse_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 64;

    localparam logic [2:0] ADDR_ENTRY_COUNT = {REG_ENTRY_COUNT, 2'b00};
    localparam logic [2:0] ADDR_SEARCH_MODE = {REG_SEARCH_MODE, 2'b00};

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } search_result_t;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tse_req_if req_ch ();
    tse_res_if res_ch ();

    table_search_engine DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the table and the registers, updated as requests are accepted.
    logic signed [VALUE_W-1:0] model_table [TABLE_DEPTH];
    int                        cfg_count = 0;
    logic                      cfg_mode  = MODE_LINEAR;

    search_result_t expected_results [$];

    int failure_count = 0;
    int result_number = 0;
    int cycle_count   = 0;
    bit idle_enable   = 1'b1;
    int hold_length   = 0;
    int hold_serial   = 0;

    always #5 clk = ~clk;

    // Expected outcome of a search over the shadow table.
    function automatic search_result_t predict_search(input logic signed [VALUE_W-1:0] target);
        search_result_t r;
        int lo;
        int hi;
        int mid;
        r = '0;
        if (cfg_mode == MODE_LINEAR)
        begin
            for (int i = 0; i < cfg_count; i++)
            begin
                if (model_table[i] == target)
                begin
                    r.found    = 1'b1;
                    r.position = POS_W'(i);
                    return r;
                end
            end
        end
        else
        begin
            lo = 0;
            hi = cfg_count - 1;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (model_table[mid] == target)
                begin
                    r.found    = 1'b1;
                    r.position = POS_W'(mid);
                    return r;
                end
                if (model_table[mid] < target)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
        end
        return r;
    endfunction

    function automatic void report_failure(input string msg);
        failure_count++;
        if (failure_count <= 10)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endfunction

    task automatic check_search_result(input logic found, input logic [POS_W-1:0] position);
        search_result_t want;
        result_number++;
        if (expected_results.size() == 0)
        begin
            report_failure($sformatf("result %0d with no search pending: found=%0b position=%0d",
                                     result_number, found, position));
            return;
        end
        want = expected_results.pop_front();
        if (found !== want.found)
            report_failure($sformatf("result %0d found: expected %0b, got %0b",
                                     result_number, want.found, found));
        if (position !== want.position)
            report_failure($sformatf("result %0d position: expected %0d, got %0d",
                                     result_number, want.position, position));
    endtask

    // Offer one request, wait for it to be taken, then update the shadow state.
    task automatic send_request(input logic op, input logic [IN_INDEX_W-1:0] index,
                                input logic signed [VALUE_W-1:0] data);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.entry_index <= index;
        req_ch.value       <= data;
        do @(posedge clk); while (!req_ch.ready);
        if (op == OP_LOAD)
        begin
            if (index < TABLE_DEPTH)
                model_table[index] = data;
        end
        else
            expected_results.push_back(predict_search(data));
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_ENTRY_COUNT)
            cfg_count = (data[CFG_COUNT_W-1:0] > TABLE_DEPTH) ? TABLE_DEPTH
                                                              : int'(data[CFG_COUNT_W-1:0]);
        else
            cfg_mode = data[0];
    endtask

    // Stop offering, let every result come back and trailing loads settle.
    task automatic wait_until_idle();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int count, input logic mode);
        wait_until_idle();
        write_register(ADDR_ENTRY_COUNT, 32'(count));
        write_register(ADDR_SEARCH_MODE, {31'b0, mode});
    endtask

    // Fill entries 0..count-1 in shuffled order, either ascending or scrambled.
    task automatic load_table(input int count, input bit ascending);
        int                        order [TABLE_DEPTH];
        logic signed [VALUE_W-1:0] entry [TABLE_DEPTH];
        longint                    level;
        int unsigned               step_max;
        int                        pick;
        int                        j;
        int                        tmp;
        pick     = $urandom_range(0, 2);
        step_max = (pick == 0) ? 3 : (pick == 1) ? 1000 : 32'hFFFF_FFFF / (count + 1);
        if (pick == 2)
            level = longint'(VALUE_MIN) + $urandom_range(0, step_max);
        else
            level = longint'($signed($urandom));
        for (int i = 0; i < count; i++)
        begin
            if (ascending)
            begin
                entry[i] = (level > longint'(VALUE_MAX)) ? VALUE_MAX : VALUE_W'(level);
                level    = level + $urandom_range(0, step_max);
            end
            else if (pick == 0)
                entry[i] = $urandom_range(0, 2 * count) - count;
            else
                entry[i] = $urandom;
            order[i] = i;
        end
        for (int i = count - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < count; i++)
            send_request(OP_LOAD, IN_INDEX_W'(order[i]), entry[order[i]]);
    endtask

    // Mostly searches for values in the table or next to them; some stray loads.
    task automatic send_random_item();
        logic signed [VALUE_W-1:0] target;
        int                        pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            send_request(OP_LOAD, IN_INDEX_W'($urandom), $urandom);
            return;
        end
        target = $urandom;
        if (cfg_count > 0 && pick < 85)
        begin
            target = model_table[$urandom_range(0, cfg_count - 1)];
            if (pick >= 65)
                target = (pick < 75) ? target + 1 : target - 1;
        end
        send_request(OP_SEARCH, IN_INDEX_W'($urandom), target);
    endtask

    task automatic run_phase(input int count, input logic mode, input bit ascending,
                             input int n_items);
        set_config(count, mode);
        load_table(cfg_count, ascending);
        repeat (n_items) send_random_item();
    endtask

    // Searches with an empty range, never touching the unwritten table.
    task automatic test_empty_table();
        send_request(OP_SEARCH, '0, 32'sd0);
        send_request(OP_SEARCH, '1, -32'sd1);
        set_config(0, MODE_BINARY);
        send_request(OP_SEARCH, '0, VALUE_MAX);
        send_request(OP_SEARCH, '1, VALUE_MIN);
    endtask

    // A small ascending table with the value extremes and a duplicate pair.
    task automatic test_directed_table();
        send_request(OP_LOAD, 10'd0, VALUE_MIN);
        send_request(OP_LOAD, 10'd1, -32'sd1);
        send_request(OP_LOAD, 10'd2, -32'sd1);
        send_request(OP_LOAD, 10'd3, 32'sd0);
        send_request(OP_LOAD, 10'd4, 32'sd1);
        send_request(OP_LOAD, 10'd5, 32'sd5);
        send_request(OP_LOAD, 10'd6, 32'sh7FFF_FFFE);
        send_request(OP_LOAD, 10'd7, VALUE_MAX);
        send_request(OP_LOAD, '1, 32'sh5555_AAAA);

        set_config(8, MODE_LINEAR);
        send_request(OP_SEARCH, '1, -32'sd1);
        send_request(OP_SEARCH, '0, VALUE_MAX);
        send_request(OP_SEARCH, '0, VALUE_MIN);
        send_request(OP_SEARCH, '0, 32'sd3);

        set_config(8, MODE_BINARY);
        send_request(OP_SEARCH, '0, -32'sd1);
        send_request(OP_SEARCH, '0, VALUE_MAX);
        send_request(OP_SEARCH, '1, VALUE_MIN);
        send_request(OP_SEARCH, '0, 32'sd3);
        send_request(OP_SEARCH, '0, 32'sd0);

        set_config(1, MODE_BINARY);
        send_request(OP_SEARCH, '0, VALUE_MIN);
        send_request(OP_SEARCH, '0, 32'sd5);
    endtask

    task automatic test_random_linear();
        run_phase(1, MODE_LINEAR, 1'b1, 20);
        repeat (3) run_phase($urandom_range(2, 32), MODE_LINEAR, 1'($urandom_range(0, 1)), 25);
    endtask

    task automatic test_random_binary();
        run_phase(1, MODE_BINARY, 1'b1, 15);
        repeat (3) run_phase($urandom_range(2, 32), MODE_BINARY, 1'b1, 25);
        run_phase($urandom_range(2, 32), MODE_BINARY, 1'b0, 25);
        run_phase($urandom_range(64, 100), MODE_BINARY, 1'b1, 30);
    endtask

    // Whole table: a saturated count in both modes and an exact full count. Only an
    // ascending prefix and the left spine of the binary probe path are written, and
    // every target is a prefix entry or a value extreme, so no search leaves them.
    task automatic test_full_table();
        set_config(32, MODE_BINARY);
        load_table(32, 1'b1);
        for (int k = 6; k <= 9; k++)
            send_request(OP_LOAD, IN_INDEX_W'((1 << k) - 1), VALUE_MAX);
        set_config(2047, MODE_BINARY);
        repeat (6)
            send_request(OP_SEARCH, IN_INDEX_W'($urandom), model_table[$urandom_range(0, 31)]);
        send_request(OP_SEARCH, '0, VALUE_MAX);
        send_request(OP_SEARCH, '1, VALUE_MIN);
        set_config(TABLE_DEPTH, MODE_BINARY);
        repeat (4)
            send_request(OP_SEARCH, IN_INDEX_W'($urandom), model_table[$urandom_range(0, 31)]);
        set_config(TABLE_DEPTH + 1, MODE_LINEAR);
        send_request(OP_SEARCH, '0, model_table[31]);
        repeat (4)
            send_request(OP_SEARCH, IN_INDEX_W'($urandom), model_table[$urandom_range(0, 31)]);
    endtask

    // The result side holds off while requests keep coming; then the sender drains.
    task automatic test_backpressure();
        set_config(24, MODE_LINEAR);
        load_table(24, 1'b1);
        hold_length = 300;
        hold_serial++;
        repeat (12) send_random_item();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (15) send_random_item();
    endtask

    task automatic test_quiet_finish();
        idle_enable = 1'b0;
        run_phase($urandom_range(2, 32), MODE_LINEAR, 1'b1, 30);
        run_phase($urandom_range(2, 32), MODE_BINARY, 1'b1, 30);
    endtask

    // Main sequence.
    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            model_table[i] = '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= OP_LOAD;
        req_ch.entry_index <= '0;
        req_ch.value       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_directed_table();
        test_random_linear();
        test_random_binary();
        test_full_table();
        test_backpressure();
        test_quiet_finish();
        wait_until_idle();

        if (failure_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result side: check each accepted result, then pick the next ready level.
    initial
    begin : result_sink
        int hold_seen;
        int hold_left;
        int stall_left;
        hold_seen    = 0;
        hold_left    = 0;
        stall_left   = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                check_search_result(res_ch.found, res_ch.position);
            if (hold_serial != hold_seen)
            begin
                hold_seen = hold_serial;
                hold_left = hold_length;
            end
            if (hold_left > 0)
                hold_left--;
            else if (stall_left > 0)
                stall_left--;
            else if (idle_enable && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 15);
            res_ch.ready <= rst_n && hold_left == 0 && stall_left == 0;
        end
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tse_pkg.sv
sv/tse_if.sv
sv/tse_front.sv
sv/tse_back.sv
sv/table_search_engine.sv
dv/table_search_engine_tb.sv
